@@ rtl/crg_pkg.sv @@
// ----------------------------------------------------------------------------
// Camera ray generator package
// Shared types, register indices and fixed-point constants.
// ----------------------------------------------------------------------------
package crg_pkg;

	// Width of a vector component entering the normaliser.
	localparam int VEC_W = 48;
	// Q1.14 direction component.
	localparam int DIR_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd4;

	localparam int TAN30_Q16 = 37837;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int CORDIC_STEPS = 14;
	localparam int STEP_W = 4;
	localparam int PITCH_LIMIT = 13107;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
	} dir_t;

	typedef struct packed {
		dir_t fwd;
		dir_t rgt;
		dir_t up;
	} basis_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_LOAD,
		BS_CORDIC,
		BS_TRIG,
		BS_FMUL,
		BS_FWD,
		BS_X1_MUL,
		BS_X1_SUB,
		BS_UP_WAIT,
		BS_X2_MUL,
		BS_X2_SUB,
		BS_RT_WAIT
	} bas_state_t;

	// Arctangent of 2^-i as a binary angle.
	function automatic logic [13:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [13:0] r;
		case (i)
			4'd0:    r = 14'd8192;
			4'd1:    r = 14'd4836;
			4'd2:    r = 14'd2555;
			4'd3:    r = 14'd1297;
			4'd4:    r = 14'd651;
			4'd5:    r = 14'd326;
			4'd6:    r = 14'd163;
			4'd7:    r = 14'd81;
			4'd8:    r = 14'd41;
			4'd9:    r = 14'd20;
			4'd10:   r = 14'd10;
			4'd11:   r = 14'd5;
			4'd12:   r = 14'd3;
			4'd13:   r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/crg_unit_norm.sv @@
// ----------------------------------------------------------------------------
// Vector normaliser
// Pipelined unit-length scaling of a three component vector to Q1.14:
// range alignment, squares, a bit-per-stage square root and a
// bit-per-stage divider in each lane.
// ----------------------------------------------------------------------------
module crg_unit_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  crg_pkg::vec_t in_vec,
	output logic          out_valid,
	output crg_pkg::dir_t out_dir
);
	localparam int MAG_W = crg_pkg::VEC_W;
	localparam int NRM_W = 30;
	localparam int SUM_W = 2 * NRM_W + 2;
	localparam int ROOT_W = NRM_W + 1;
	localparam int SQ_STEPS = SUM_W / 2;
	localparam int REM_W = ROOT_W + 5;
	localparam int Q_W = 15;
	localparam int DEN_W = ROOT_W + 1;
	localparam int NUM_W = DEN_W + Q_W;
	localparam int POS_W = $clog2(MAG_W);

	// Stage 1: magnitudes and largest magnitude.
	logic signed [MAG_W-1:0] comp [0:2];
	logic [MAG_W-1:0] mag_c [0:2];
	logic [MAG_W-1:0] mx_c;
	logic v_s1;
	logic [MAG_W-1:0] mag_s1 [0:2];
	logic [2:0] neg_s1;
	logic [MAG_W-1:0] mx_s1;

	assign comp[0] = in_vec.x;
	assign comp[1] = in_vec.y;
	assign comp[2] = in_vec.z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = comp[i][MAG_W-1] ? MAG_W'(-comp[i]) : MAG_W'(comp[i]);
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			mx_s1 <= mx_c;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][MAG_W-1];
			end
		end
	end

	// Stage 2: position of the leading one sets the alignment shift.
	logic [POS_W-1:0] pos_c;
	logic v_s2;
	logic [MAG_W-1:0] mag_s2 [0:2];
	logic [2:0] neg_s2;
	logic zero_s2;
	logic right_s2;
	logic [POS_W-1:0] amt_s2;

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mx_s1[i]) pos_c = POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			zero_s2 <= (mx_s1 == '0);
			if (pos_c >= POS_W'(NRM_W - 1)) begin
				right_s2 <= 1'b1;
				amt_s2 <= pos_c - POS_W'(NRM_W - 1);
			end else begin
				right_s2 <= 1'b0;
				amt_s2 <= POS_W'(NRM_W - 1) - pos_c;
			end
		end
	end

	// Stage 3: the largest magnitude lands in [2^29, 2^30).
	logic v_s3;
	logic [NRM_W-1:0] mn_s3 [0:2];
	logic [2:0] neg_s3;
	logic zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++) begin
				if (right_s2) mn_s3[i] <= NRM_W'(mag_s2[i] >> amt_s2);
				else          mn_s3[i] <= NRM_W'(mag_s2[i] << amt_s2);
			end
		end
	end

	// Stage 4: squares.
	logic v_s4;
	logic [2*NRM_W-1:0] sq_s4 [0:2];
	logic [NRM_W-1:0] mn_s4 [0:2];
	logic [2:0] neg_s4;
	logic zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s4 <= mn_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (2*NRM_W)'(mn_s3[i]) * (2*NRM_W)'(mn_s3[i]);
			end
		end
	end

	// Stage 5: sum of squares, the first word of the root pipeline.
	logic sq_v_s [0:SQ_STEPS];
	logic [SUM_W-1:0] sq_sum_s [0:SQ_STEPS];
	logic [REM_W-1:0] sq_rem_s [0:SQ_STEPS];
	logic [ROOT_W-1:0] sq_root_s [0:SQ_STEPS];
	logic [NRM_W-1:0] sq_mn_s [0:SQ_STEPS][0:2];
	logic [2:0] sq_neg_s [0:SQ_STEPS];
	logic sq_zero_s [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_sum_s[0] <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
			sq_mn_s[0] <= mn_s4;
			sq_neg_s[0] <= neg_s4;
			sq_zero_s[0] <= zero_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sq_v_s[0] <= v_s4;
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [REM_W-1:0] nxt;
		logic [REM_W-1:0] trial;

		assign nxt = {sq_rem_s[k][REM_W-3:0], sq_sum_s[k][SUM_W-1-2*k -: 2]};
		assign trial = {{(REM_W-ROOT_W-2){1'b0}}, sq_root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (nxt >= trial) begin
					sq_rem_s[k+1] <= nxt - trial;
					sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_s[k+1] <= nxt;
					sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], 1'b0};
				end
				sq_sum_s[k+1] <= sq_sum_s[k];
				sq_mn_s[k+1] <= sq_mn_s[k];
				sq_neg_s[k+1] <= sq_neg_s[k];
				sq_zero_s[k+1] <= sq_zero_s[k];
			end
		end
	end

	// Divider set-up: numerator m*2^15 + n over denominator 2n, rounding
	// to nearest.
	logic dv_v_s [0:Q_W];
	logic [NUM_W-1:0] dv_rem_s [0:Q_W][0:2];
	logic [Q_W-1:0] dv_q_s [0:Q_W][0:2];
	logic [DEN_W-1:0] dv_den_s [0:Q_W];
	logic [2:0] dv_neg_s [0:Q_W];
	logic dv_zero_s [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_den_s[0] <= {sq_root_s[SQ_STEPS], 1'b0};
			dv_neg_s[0] <= sq_neg_s[SQ_STEPS];
			dv_zero_s[0] <= sq_zero_s[SQ_STEPS];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= NUM_W'({sq_mn_s[SQ_STEPS][i], {Q_W{1'b0}}})
					+ NUM_W'(sq_root_s[SQ_STEPS]);
				dv_q_s[0][i] <= '0;
			end
		end
	end

	// Restoring division, one quotient bit per stage, three lanes.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [NUM_W-1:0] dsh;

		assign dsh = NUM_W'(dv_den_s[j]) << (Q_W - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[j][i] >= dsh) begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i] - dsh;
						dv_q_s[j+1][i] <= {dv_q_s[j][i][Q_W-2:0], 1'b1};
					end else begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i];
						dv_q_s[j+1][i] <= {dv_q_s[j][i][Q_W-2:0], 1'b0};
					end
				end
				dv_den_s[j+1] <= dv_den_s[j];
				dv_neg_s[j+1] <= dv_neg_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
			end
		end
	end

	// Output: signs restored, a zero vector gives zero.
	logic signed [crg_pkg::DIR_W-1:0] res_c [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[Q_W]) begin
				res_c[i] = '0;
			end else if (dv_neg_s[Q_W][i]) begin
				res_c[i] = -$signed(crg_pkg::DIR_W'(dv_q_s[Q_W][i]));
			end else begin
				res_c[i] = $signed(crg_pkg::DIR_W'(dv_q_s[Q_W][i]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dir.x <= res_c[0];
			out_dir.y <= res_c[1];
			out_dir.z <= res_c[2];
		end
	end

endmodule

@@ rtl/crg_basis.sv @@
// ----------------------------------------------------------------------------
// Camera basis engine
// Sequencer that turns yaw and pitch into the forward, right and up
// vectors: iterative CORDIC for both angles, then two cross products,
// each made unit length through the one shared normaliser.
// ----------------------------------------------------------------------------
module crg_basis (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [15:0]     yaw,
	input  logic [14:0]     pitch,
	output logic            busy,
	output crg_pkg::basis_t basis
);
	localparam int XW = 34;
	localparam int ZW = 18;
	localparam int PW = 2 * crg_pkg::DIR_W;
	localparam int DW = crg_pkg::DIR_W;

	crg_pkg::bas_state_t state_q, state_d;

	logic [crg_pkg::STEP_W-1:0] step_q;
	logic signed [XW-1:0] cx_q [0:1];
	logic signed [XW-1:0] cy_q [0:1];
	logic signed [ZW-1:0] cz_q [0:1];
	logic [1:0] neg_q;
	logic signed [DW-1:0] sin_yaw_q, cos_yaw_q, sin_pitch_q, cos_pitch_q;
	logic signed [PW-1:0] prod_q [0:5];
	crg_pkg::dir_t fwd_q, rgt_q, up_q;
	crg_pkg::dir_t xa, xb;
	crg_pkg::vec_t u_vec_q;
	logic u_v_q;
	logic u_ov;
	crg_pkg::dir_t u_dir;
	logic signed [15:0] ang [0:1];
	logic signed [14:0] pitch_sat;

	function automatic logic signed [DW-1:0] trig_round(
		input logic signed [XW-1:0] v,
		input logic neg
	);
		logic signed [XW-1:0] r;
		logic signed [ZW-1:0] c;
		r = (v + XW'(32768)) >>> 16;
		c = ZW'(r);
		if (c > ZW'(16384)) c = ZW'(16384);
		if (c < -ZW'(16384)) c = -ZW'(16384);
		if (neg) c = -c;
		return DW'(c);
	endfunction

	crg_unit_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (1'b1),
		.in_valid (u_v_q),
		.in_vec   (u_vec_q),
		.out_valid(u_ov),
		.out_dir  (u_dir)
	);

	always_comb begin
		pitch_sat = $signed(pitch);
		if (pitch_sat > 15'(crg_pkg::PITCH_LIMIT)) pitch_sat = 15'(crg_pkg::PITCH_LIMIT);
		if (pitch_sat < -15'(crg_pkg::PITCH_LIMIT)) pitch_sat = -15'(crg_pkg::PITCH_LIMIT);
		ang[0] = $signed(yaw);
		ang[1] = 16'(pitch_sat);
	end

	// The first cross product takes forward and right, the second up and
	// forward.
	always_comb begin
		if (state_q == crg_pkg::BS_X2_MUL) begin
			xa = up_q;
			xb = fwd_q;
		end else begin
			xa = fwd_q;
			xb = rgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crg_pkg::BS_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		case (state_q)
			crg_pkg::BS_IDLE: begin
				busy = 1'b0;
				if (start) state_d = crg_pkg::BS_LOAD;
			end
			crg_pkg::BS_LOAD:    state_d = crg_pkg::BS_CORDIC;
			crg_pkg::BS_CORDIC: begin
				if (step_q == crg_pkg::STEP_W'(crg_pkg::CORDIC_STEPS - 1)) begin
					state_d = crg_pkg::BS_TRIG;
				end
			end
			crg_pkg::BS_TRIG:    state_d = crg_pkg::BS_FMUL;
			crg_pkg::BS_FMUL:    state_d = crg_pkg::BS_FWD;
			crg_pkg::BS_FWD:     state_d = crg_pkg::BS_X1_MUL;
			crg_pkg::BS_X1_MUL:  state_d = crg_pkg::BS_X1_SUB;
			crg_pkg::BS_X1_SUB:  state_d = crg_pkg::BS_UP_WAIT;
			crg_pkg::BS_UP_WAIT: begin
				if (u_ov) state_d = crg_pkg::BS_X2_MUL;
			end
			crg_pkg::BS_X2_MUL:  state_d = crg_pkg::BS_X2_SUB;
			crg_pkg::BS_X2_SUB:  state_d = crg_pkg::BS_RT_WAIT;
			crg_pkg::BS_RT_WAIT: begin
				if (u_ov) state_d = crg_pkg::BS_IDLE;
			end
			default:             state_d = crg_pkg::BS_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_v_q <= 1'b0;
		end else begin
			u_v_q <= (state_q == crg_pkg::BS_X1_SUB) || (state_q == crg_pkg::BS_X2_SUB);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crg_pkg::BS_LOAD: begin
				step_q <= '0;
				for (int l = 0; l < 2; l++) begin
					cx_q[l] <= XW'(crg_pkg::CORDIC_GAIN_Q30);
					cy_q[l] <= '0;
					// Fold the angle into a half turn about zero.
					if (ZW'(ang[l]) > ZW'(16384)) begin
						cz_q[l] <= ZW'(ang[l]) - ZW'(32768);
						neg_q[l] <= 1'b1;
					end else if (ZW'(ang[l]) < -ZW'(16384)) begin
						cz_q[l] <= ZW'(ang[l]) + ZW'(32768);
						neg_q[l] <= 1'b1;
					end else begin
						cz_q[l] <= ZW'(ang[l]);
						neg_q[l] <= 1'b0;
					end
				end
			end
			crg_pkg::BS_CORDIC: begin
				step_q <= step_q + 1'b1;
				for (int l = 0; l < 2; l++) begin
					if (cz_q[l] >= 0) begin
						cx_q[l] <= cx_q[l] - (cy_q[l] >>> step_q);
						cy_q[l] <= cy_q[l] + (cx_q[l] >>> step_q);
						cz_q[l] <= cz_q[l] - $signed(ZW'(crg_pkg::atan_lut(step_q)));
					end else begin
						cx_q[l] <= cx_q[l] + (cy_q[l] >>> step_q);
						cy_q[l] <= cy_q[l] - (cx_q[l] >>> step_q);
						cz_q[l] <= cz_q[l] + $signed(ZW'(crg_pkg::atan_lut(step_q)));
					end
				end
			end
			crg_pkg::BS_TRIG: begin
				sin_yaw_q <= trig_round(cy_q[0], neg_q[0]);
				cos_yaw_q <= trig_round(cx_q[0], neg_q[0]);
				sin_pitch_q <= trig_round(cy_q[1], neg_q[1]);
				cos_pitch_q <= trig_round(cx_q[1], neg_q[1]);
			end
			crg_pkg::BS_FMUL: begin
				prod_q[0] <= PW'(sin_yaw_q) * PW'(cos_pitch_q);
				prod_q[1] <= PW'(cos_yaw_q) * PW'(cos_pitch_q);
			end
			crg_pkg::BS_FWD: begin
				fwd_q.x <= DW'((prod_q[0] + PW'(8192)) >>> 14);
				fwd_q.y <= sin_pitch_q;
				fwd_q.z <= -DW'((prod_q[1] + PW'(8192)) >>> 14);
				rgt_q.x <= cos_yaw_q;
				rgt_q.y <= '0;
				rgt_q.z <= sin_yaw_q;
			end
			crg_pkg::BS_X1_MUL, crg_pkg::BS_X2_MUL: begin
				prod_q[0] <= PW'(xa.y) * PW'(xb.z);
				prod_q[1] <= PW'(xa.z) * PW'(xb.y);
				prod_q[2] <= PW'(xa.z) * PW'(xb.x);
				prod_q[3] <= PW'(xa.x) * PW'(xb.z);
				prod_q[4] <= PW'(xa.x) * PW'(xb.y);
				prod_q[5] <= PW'(xa.y) * PW'(xb.x);
			end
			crg_pkg::BS_X1_SUB, crg_pkg::BS_X2_SUB: begin
				u_vec_q.x <= crg_pkg::VEC_W'(prod_q[0]) - crg_pkg::VEC_W'(prod_q[1]);
				u_vec_q.y <= crg_pkg::VEC_W'(prod_q[2]) - crg_pkg::VEC_W'(prod_q[3]);
				u_vec_q.z <= crg_pkg::VEC_W'(prod_q[4]) - crg_pkg::VEC_W'(prod_q[5]);
			end
			crg_pkg::BS_UP_WAIT: begin
				if (u_ov) up_q <= u_dir;
			end
			crg_pkg::BS_RT_WAIT: begin
				if (u_ov) rgt_q <= u_dir;
			end
			default: begin
			end
		endcase
	end

	assign basis.fwd = fwd_q;
	assign basis.rgt = rgt_q;
	assign basis.up = up_q;

endmodule

@@ rtl/camera_ray_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Camera ray generator
// Primary ray of a pinhole camera with a 60 degree field of view, one ray
// per pixel: origin at the camera, unit direction in Q1.14.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//  in       in_valid/in_ready      pixel_x, pixel_y
//  out      out_valid/out_ready    origin_x/y/z, dir_x/y/z
//
// One word enters per cycle while in_ready is high; each result passes
// the camera-vector stage, the basis-transform stages and the two
// normalisers (53 stages each: square root and divider one bit per stage).
// After reset and after each yaw or pitch write the basis engine runs;
// in_ready and cfg_ready stay low meanwhile.
// When out_ready is low with a result waiting, the whole pipeline holds.
// ----------------------------------------------------------------------------
module camera_ray_generator_unit #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [crg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [9:0]                       pixel_x,
	input  logic [8:0]                       pixel_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               origin_x,
	output logic signed [31:0]               origin_y,
	output logic signed [31:0]               origin_z,
	output logic signed [crg_pkg::DIR_W-1:0] dir_x,
	output logic signed [crg_pkg::DIR_W-1:0] dir_y,
	output logic signed [crg_pkg::DIR_W-1:0] dir_z
);
	localparam int VW = crg_pkg::VEC_W;
	localparam int PW = 2 * crg_pkg::DIR_W;
	localparam logic signed [VW-1:0] CAM_Z = -(VW'(SCREEN_HEIGHT) <<< 16);

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [15:0] yaw_q;
	logic [14:0] pitch_q;
	logic cfg_we;
	logic start;
	logic busy;
	logic en;
	crg_pkg::basis_t basis;

	assign en = !out_valid || out_ready;
	assign in_ready = en && !busy;
	assign cfg_ready = !busy;
	assign cfg_we = cfg_valid && cfg_ready;
	assign start = cfg_we && (cfg_index inside {crg_pkg::REG_YAW, crg_pkg::REG_PITCH});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				crg_pkg::REG_CAM_X: cam_x_q <= cfg_data;
				crg_pkg::REG_CAM_Y: cam_y_q <= cfg_data;
				crg_pkg::REG_CAM_Z: cam_z_q <= cfg_data;
				crg_pkg::REG_YAW:   yaw_q <= cfg_data[15:0];
				crg_pkg::REG_PITCH: pitch_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	crg_basis u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.yaw    (yaw_q),
		.pitch  (pitch_q),
		.busy   (busy),
		.basis  (basis)
	);

	// Camera-space vector; the common 1/H factor cancels in normalisation.
	logic signed [13:0] ox, oy;
	logic cam_v_s1;
	crg_pkg::vec_t cam_s1;

	assign ox = $signed({3'b0, pixel_x, 1'b1}) - 14'(SCREEN_WIDTH);
	assign oy = $signed({4'b0, pixel_y, 1'b0}) - 14'(SCREEN_HEIGHT + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_v_s1 <= 1'b0;
		end else if (en) begin
			cam_v_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s1.x <= VW'(32'(ox) * 32'(crg_pkg::TAN30_Q16));
			cam_s1.y <= VW'(32'(oy) * 32'(crg_pkg::TAN30_Q16));
			cam_s1.z <= CAM_Z;
		end
	end

	logic d_v;
	crg_pkg::dir_t d_dir;

	crg_unit_norm u_norm_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cam_v_s1),
		.in_vec   (cam_s1),
		.out_valid(d_v),
		.out_dir  (d_dir)
	);

	// Basis transform: nine products, then three sums.
	logic mp_v_s2;
	logic signed [PW-1:0] mp_s2 [0:8];
	logic mv_v_s3;
	crg_pkg::vec_t mv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_v_s2 <= 1'b0;
			mv_v_s3 <= 1'b0;
		end else if (en) begin
			mp_v_s2 <= d_v;
			mv_v_s3 <= mp_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s2[0] <= PW'(d_dir.x) * PW'(basis.rgt.x);
			mp_s2[1] <= PW'(d_dir.y) * PW'(basis.up.x);
			mp_s2[2] <= PW'(d_dir.z) * PW'(basis.fwd.x);
			mp_s2[3] <= PW'(d_dir.x) * PW'(basis.rgt.y);
			mp_s2[4] <= PW'(d_dir.y) * PW'(basis.up.y);
			mp_s2[5] <= PW'(d_dir.z) * PW'(basis.fwd.y);
			mp_s2[6] <= PW'(d_dir.x) * PW'(basis.rgt.z);
			mp_s2[7] <= PW'(d_dir.y) * PW'(basis.up.z);
			mp_s2[8] <= PW'(d_dir.z) * PW'(basis.fwd.z);
			mv_s3.x <= VW'(mp_s2[0]) + VW'(mp_s2[1]) + VW'(mp_s2[2]);
			mv_s3.y <= VW'(mp_s2[3]) + VW'(mp_s2[4]) + VW'(mp_s2[5]);
			mv_s3.z <= VW'(mp_s2[6]) + VW'(mp_s2[7]) + VW'(mp_s2[8]);
		end
	end

	crg_pkg::dir_t res_dir;

	crg_unit_norm u_norm_world (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mv_v_s3),
		.in_vec   (mv_s3),
		.out_valid(out_valid),
		.out_dir  (res_dir)
	);

	assign dir_x = res_dir.x;
	assign dir_y = res_dir.y;
	assign dir_z = res_dir.z;
	assign origin_x = cam_x_q;
	assign origin_y = cam_y_q;
	assign origin_z = cam_z_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera ray generator testbench
// Streams pixel coordinates through the block under several camera settings,
// predicts each primary ray in fixed point and checks every result word.
// ----------------------------------------------------------------------------
module tb;

	localparam int SCR_W = 640;
	localparam int SCR_H = 480;
	localparam logic [crg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [crg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 700;

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [15:0] dx, dy, dz;
	} ray_t;

	typedef struct {
		logic [9:0] px;
		logic [8:0] py;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [crg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [crg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [9:0] pixel_x = '0;
	logic [8:0] pixel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [15:0] dir_x, dir_y, dir_z;

	// Camera registers as the block should hold them.
	logic signed [31:0] cam_x = 0, cam_y = 0, cam_z = 0;
	logic [15:0] cam_yaw = 0;
	logic [14:0] cam_pitch = 0;

	pixel_t pixel_q[$];
	ray_t ray_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	logic hold_go = 1'b0;
	logic hold_started = 1'b0;
	int hold_left = 0;

	camera_ray_generator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
	);

	always #5 clk = ~clk;

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic void sin_cos(input int ang, output int sn, output int cs);
		int a;
		bit neg;
		longint xv, yv, zv, dx, dy, c, s;
		a = ang & 16'hFFFF;
		neg = 0;
		xv = crg_pkg::CORDIC_GAIN_Q30;
		yv = 0;
		if (a >= 32768) a -= 65536;
		if (a > 16384) begin
			a -= 32768;
			neg = 1;
		end else if (a < -16384) begin
			a += 32768;
			neg = 1;
		end
		zv = a;
		for (int i = 0; i < crg_pkg::CORDIC_STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (zv >= 0) begin
				xv -= dx; yv += dy; zv -= crg_pkg::atan_lut(crg_pkg::STEP_W'(i));
			end else begin
				xv += dx; yv -= dy; zv += crg_pkg::atan_lut(crg_pkg::STEP_W'(i));
			end
		end
		c = rnd_shift(xv, 16);
		s = rnd_shift(yv, 16);
		if (c > 16384) c = 16384;
		if (c < -16384) c = -16384;
		if (s > 16384) s = 16384;
		if (s < -16384) s = -16384;
		if (neg) begin
			c = -c; s = -s;
		end
		sn = int'(s);
		cs = int'(c);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Block floating point normalisation to Q1.14, signs kept apart.
	function automatic void normalise(input longint v[3], output int o[3]);
		longint unsigned m[3], mx, sum, n, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] <<= 1;
			mx <<= 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		n = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 32768 + n) / (2 * n);
			o[i] = v[i] < 0 ? -int'(q) : int'(q);
		end
	endfunction

	function automatic void cross_prod(input int a[3], input int b[3], output longint c[3]);
		c[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
		c[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
		c[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
	endfunction

	function automatic ray_t predict_ray(logic [9:0] px, logic [8:0] py);
		longint cv[3], t[3];
		int d[3], fwd[3], rgt[3], up[3], res[3];
		int sy, cy, sp, cp, pit;
		ray_t r;
		cv[0] = (2 * longint'(px) + 1 - SCR_W) * crg_pkg::TAN30_Q16;
		cv[1] = (2 * longint'(py) - 1 - SCR_H) * crg_pkg::TAN30_Q16;
		cv[2] = -longint'(SCR_H) * 65536;
		normalise(cv, d);
		pit = int'(signed'(cam_pitch));
		if (pit > crg_pkg::PITCH_LIMIT) pit = crg_pkg::PITCH_LIMIT;
		if (pit < -crg_pkg::PITCH_LIMIT) pit = -crg_pkg::PITCH_LIMIT;
		sin_cos(cam_yaw, sy, cy);
		sin_cos(pit & 16'hFFFF, sp, cp);
		fwd[0] = int'(rnd_shift(longint'(sy) * cp, 14));
		fwd[1] = sp;
		fwd[2] = -int'(rnd_shift(longint'(cy) * cp, 14));
		rgt = '{cy, 0, sy};
		cross_prod(fwd, rgt, t);
		normalise(t, up);
		cross_prod(up, fwd, t);
		normalise(t, rgt);
		for (int i = 0; i < 3; i++)
			t[i] = longint'(d[0]) * rgt[i] + longint'(d[1]) * up[i] + longint'(d[2]) * fwd[i];
		normalise(t, res);
		r.ox = cam_x; r.oy = cam_y; r.oz = cam_z;
		r.dx = 16'(res[0]); r.dy = 16'(res[1]); r.dz = 16'(res[2]);
		return r;
	endfunction

	// Pixel driver; the expected ray is computed as each word is taken.
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) ray_q.push_back(predict_ray(pixel_x, pixel_y));
			if (!in_valid || in_ready) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					p = pixel_q.pop_front();
					in_valid <= 1'b1;
					pixel_x <= p.px;
					pixel_y <= p.py;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : ray_monitor
		ray_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (ray_q.size() == 0) begin
					$display("%0t: unexpected ray dir %0d %0d %0d", $time, dir_x, dir_y, dir_z);
					errors++;
				end else begin
					e = ray_q.pop_front();
					if (origin_x !== e.ox) begin
						$display("%0t: origin_x exp %0d got %0d", $time, e.ox, origin_x);
						errors++;
					end
					if (origin_y !== e.oy) begin
						$display("%0t: origin_y exp %0d got %0d", $time, e.oy, origin_y);
						errors++;
					end
					if (origin_z !== e.oz) begin
						$display("%0t: origin_z exp %0d got %0d", $time, e.oz, origin_z);
						errors++;
					end
					if (dir_x !== e.dx) begin
						$display("%0t: dir_x exp %0d got %0d", $time, e.dx, dir_x);
						errors++;
					end
					if (dir_y !== e.dy) begin
						$display("%0t: dir_y exp %0d got %0d", $time, e.dy, dir_y);
						errors++;
					end
					if (dir_z !== e.dz) begin
						$display("%0t: dir_z exp %0d got %0d", $time, e.dz, dir_z);
						errors++;
					end
				end
			end
			if (hold_go && !hold_started) begin
				hold_started <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= recv_idle;
			end
		end
	end

	task automatic write_reg(logic [crg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			crg_pkg::REG_CAM_X: cam_x = val;
			crg_pkg::REG_CAM_Y: cam_y = val;
			crg_pkg::REG_CAM_Z: cam_z = val;
			crg_pkg::REG_YAW:   cam_yaw = val[15:0];
			crg_pkg::REG_PITCH: cam_pitch = val[14:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] yaw, logic [14:0] pitch);
		// Upper data bits beyond each register carry noise that must be dropped.
		write_reg(crg_pkg::REG_CAM_X, x);
		write_reg(crg_pkg::REG_CAM_Y, y);
		write_reg(crg_pkg::REG_CAM_Z, z);
		write_reg(crg_pkg::REG_YAW, {16'($urandom_range(65535)), yaw});
		write_reg(crg_pkg::REG_PITCH, {17'($urandom_range(131071)), pitch});
		write_reg(crg_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_pixel(int x, int y);
		pixel_t p;
		p.px = 10'(x);
		p.py = 9'(y);
		pixel_q.push_back(p);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) add_pixel($urandom_range(1023), $urandom_range(511));
			else add_pixel($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1));
		end
	endtask

	task automatic drain();
		do @(posedge clk); while (pixel_q.size() != 0 || in_valid || ray_q.size() != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 37;
		recv_idle = 58;

		// Screen corners, centre, off-screen pixels and alternating bit patterns.
		add_pixel(0, 0);
		add_pixel(SCR_W - 1, SCR_H - 1);
		add_pixel(0, SCR_H - 1);
		add_pixel(SCR_W - 1, 0);
		add_pixel(SCR_W / 2, SCR_H / 2);
		add_pixel(SCR_W / 2 - 1, SCR_H / 2 - 1);
		add_pixel(1023, 511);
		add_pixel(1023, 0);
		add_pixel(0, 511);
		add_pixel(640, 480);
		add_pixel(682, 341);
		add_pixel(341, 170);
		add_pixel(512, 256);
		add_pixel(1, 1);
		drain();

		set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 16'd65535, 15'd13107);
		add_pixel(0, 0);
		add_pixel(SCR_W - 1, SCR_H - 1);
		add_random(200);
		drain();
		set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 16'd16384,
			15'(-13107));
		add_random(200);
		drain();

		send_idle = 58;
		recv_idle = 37;
		set_camera($urandom, $urandom, $urandom, 16'd32768, 15'h7FFF);
		add_random(200);
		drain();
		// Raw pitch values beyond the limit in both directions.
		set_camera($urandom, $urandom, $urandom, 16'd49152, 15'h4000);
		add_random(200);
		drain();
		set_camera(0, 0, 0, 16'd0, 15'h3FFF);
		add_random(200);
		drain();

		send_idle = 0;
		recv_idle = 0;
		set_camera($urandom, $urandom, $urandom, 16'($urandom),
			15'($urandom_range(32767)));
		add_random(250);
		hold_go <= 1'b1;
		drain();
		set_camera($urandom, $urandom, $urandom, 16'($urandom),
			15'($urandom_range(32767)));
		add_random(250);
		drain();

		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("** camera_ray_generator_unit: PASSED **");
		else
			$display("** camera_ray_generator_unit: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** camera_ray_generator_unit: FAILED **");
		$finish;
	end

endmodule
